@@ rtl/lpf_pkg.sv @@
package lpf_pkg;

   localparam int REG_W       = 11;
   localparam int SAMPLE_W    = 32;
   localparam int CSR_INDEX_W = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [REG_W-1:0]           reg_type;
   typedef logic [CSR_INDEX_W-1:0]     csr_index_type;

   localparam csr_index_type CSR_FRAME_WIDTH  = 2'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 2'd1;

   localparam sample_type BORDER_VALUE = sample_type'(-9999999);

   // stage tag for a cell under test
   typedef struct packed {
      logic    valid;
      logic    sweep;
      logic    first_row;
      logic    first_col;
      logic    last_col;
      logic    final_item;
      reg_type row;
      reg_type col;
   } tag_type;

   typedef struct packed {
      logic    found;
      reg_type row;
      reg_type col;
   } result_type;

endpackage

@@ rtl/lpf_ifs.sv @@
interface lpf_req_if;
   import lpf_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface lpf_rsp_if;
   import lpf_pkg::*;
   logic    valid;
   logic    ready;
   logic    peak_found;
   reg_type peak_row;
   reg_type peak_column;
   modport source (output valid, output peak_found, output peak_row, output peak_column,
                   input ready);
   modport sink (input valid, input peak_found, input peak_row, input peak_column,
                 output ready);
endinterface

interface lpf_csr_if;
   import lpf_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   reg_type       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/lpf_line_store.sv @@
module lpf_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_next,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  lpf_pkg::sample_type      wr_up,
   input  lpf_pkg::sample_type      wr_mid,
   output lpf_pkg::sample_type      up_q,
   output lpf_pkg::sample_type      mid_q,
   output lpf_pkg::sample_type      right_q
);
   import lpf_pkg::*;

   sample_type up_mem [DEPTH];
   sample_type mid_mem [DEPTH];

   sample_type up_rd_ff;
   sample_type mid_rd_ff;
   sample_type right_rd_ff;
   sample_type fwd_up_ff;
   sample_type fwd_mid_ff;
   logic       fwd_c_ff;
   logic       fwd_r_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         up_mem[wr_addr]  <= wr_up;
         mid_mem[wr_addr] <= wr_mid;
      end
      if (rd_en) begin
         up_rd_ff    <= up_mem[rd_addr];
         mid_rd_ff   <= mid_mem[rd_addr];
         right_rd_ff <= mid_mem[rd_addr_next];
         // write in flight to the same entry wins
         fwd_c_ff    <= wr_en && (wr_addr == rd_addr);
         fwd_r_ff    <= wr_en && (wr_addr == rd_addr_next);
         fwd_up_ff   <= wr_up;
         fwd_mid_ff  <= wr_mid;
      end
   end

   assign up_q    = fwd_c_ff ? fwd_up_ff  : up_rd_ff;
   assign mid_q   = fwd_c_ff ? fwd_mid_ff : mid_rd_ff;
   assign right_q = fwd_r_ff ? fwd_mid_ff : right_rd_ff;

endmodule

@@ rtl/lpf_peak_track.sv @@
module lpf_peak_track (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  lpf_pkg::tag_type     tag,
   input  lpf_pkg::sample_type  sample,
   input  lpf_pkg::sample_type  up,
   input  lpf_pkg::sample_type  mid,
   input  lpf_pkg::sample_type  right,
   output lpf_pkg::result_type  result,
   output logic                 done
);
   import lpf_pkg::*;

   sample_type left_ff;
   sample_type best_value_ff;
   reg_type    best_row_ff;
   reg_type    best_col_ff;
   logic       found_ff;

   sample_type left_val;
   sample_type right_val;
   sample_type down_val;
   logic       is_peak;
   logic       take;

   always_comb begin
      left_val  = tag.first_col ? BORDER_VALUE : left_ff;
      right_val = tag.last_col  ? BORDER_VALUE : right;
      down_val  = tag.sweep     ? BORDER_VALUE : sample;
      is_peak   = (mid > up) && (mid > down_val) && (mid > left_val) && (mid > right_val);
      take      = tag.valid && !tag.first_row && is_peak
                  && (!found_ff || (mid < best_value_ff));
      done         = tag.valid && tag.final_item;
      result.found = found_ff || take;
      result.row   = take ? tag.row : best_row_ff;
      result.col   = take ? tag.col : best_col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || clear || done) begin
         found_ff      <= 1'b0;
         best_value_ff <= '0;
         best_row_ff   <= '0;
         best_col_ff   <= '0;
      end else if (take) begin
         found_ff      <= 1'b1;
         best_value_ff <= mid;
         best_row_ff   <= tag.row;
         best_col_ff   <= tag.col;
      end
   end

   // previous middle-row cell is the left neighbour
   always_ff @(posedge clock) begin
      if (tag.valid) begin
         left_ff <= mid;
      end
   end

endmodule

@@ rtl/lowest_local_peak_finder.sv @@
// Accepts one sample per clock inside a frame; the two line stores are read in the cycle a sample
// is accepted. After the last sample of a frame the bottom row is rescanned from the line store,
// which holds off requests for the rescan, longer while the previous result waits; the result
// is registered once the rescan has checked the last cell of the bottom row.
// Reset clears counters, the running minimum and the result register and sets both sizes
// to 1; the line stores are not cleared and hold nothing a frame reads before writing it.
module lowest_local_peak_finder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input logic        clock,
   input logic        reset,
   lpf_req_if.sink    req_bus,
   lpf_rsp_if.source  rsp_bus,
   lpf_csr_if.sink    csr_bus
);
   import lpf_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

   typedef enum logic [1:0] {
      ST_STREAM,
      ST_WAIT,
      ST_SWEEP
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  w_eff_ff;
   logic [HCNT_W-1:0] h_eff_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   tag_type           tag_ff;
   tag_type           tag_in;
   logic [COL_W-1:0]  addr_ff;
   sample_type        sample_ff;
   logic              rsp_valid_ff;
   result_type        rsp_ff;

   logic [CNT_W-1:0]  col_next;
   logic [HCNT_W-1:0] row_next;
   logic              last_col;
   logic              last_row;
   logic              req_acc;
   logic              csr_acc;
   logic              cfg_hit;
   logic              sweep;
   logic              issue;
   logic [COL_W-1:0]  rd_addr_next;
   logic              wr_en;
   sample_type        wr_up;
   sample_type        up_q;
   sample_type        mid_q;
   sample_type        right_q;
   result_type        result;
   logic              done;

   function automatic logic [31:0] clamp_size(input reg_type raw, input int maxv);
      logic [31:0] v;
      v = 32'(raw);
      if (v == 32'd0) begin
         v = 32'd1;
      end else if (v > 32'(maxv)) begin
         v = 32'(maxv);
      end
      return v;
   endfunction

   assign req_bus.ready = (state_ff == ST_STREAM);
   assign csr_bus.ready = 1'b1;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_acc       = csr_bus.valid && csr_bus.ready;
   assign cfg_hit       = csr_acc && ((csr_bus.index == CSR_FRAME_WIDTH)
                                      || (csr_bus.index == CSR_FRAME_HEIGHT));

   assign col_next     = CNT_W'(col_ff) + CNT_W'(1);
   assign row_next     = HCNT_W'(row_ff) + HCNT_W'(1);
   assign last_col     = (col_next == w_eff_ff);
   assign last_row     = (row_next == h_eff_ff);
   assign sweep        = (state_ff == ST_SWEEP);
   assign issue        = req_acc || sweep;
   assign rd_addr_next = last_col ? '0 : COL_W'(col_next);

   always_comb begin
      tag_in.valid      = issue;
      tag_in.sweep      = sweep;
      tag_in.first_row  = !sweep && (row_ff == '0);
      tag_in.first_col  = (col_ff == '0);
      tag_in.last_col   = last_col;
      tag_in.final_item = sweep && last_col;
      tag_in.row        = sweep ? REG_W'(h_eff_ff) : REG_W'(row_ff);
      tag_in.col        = REG_W'(col_next);
   end

   // row 0 seeds the upper store with the border row
   assign wr_en = tag_ff.valid && !tag_ff.sweep;
   assign wr_up = tag_ff.first_row ? BORDER_VALUE : mid_q;

   lpf_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock        (clock),
      .rd_en        (issue),
      .rd_addr      (col_ff),
      .rd_addr_next (rd_addr_next),
      .wr_en        (wr_en),
      .wr_addr      (addr_ff),
      .wr_up        (wr_up),
      .wr_mid       (sample_ff),
      .up_q         (up_q),
      .mid_q        (mid_q),
      .right_q      (right_q)
   );

   lpf_peak_track u_peak_track (
      .clock  (clock),
      .reset  (reset),
      .clear  (cfg_hit),
      .tag    (tag_ff),
      .sample (sample_ff),
      .up     (up_q),
      .mid    (mid_q),
      .right  (right_q),
      .result (result),
      .done   (done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STREAM;
         w_eff_ff     <= CNT_W'(1);
         h_eff_ff     <= HCNT_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_ff       <= '0;
      end else begin
         tag_ff <= tag_in;

         if (done) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= result;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cfg_hit) begin
            unique case (csr_bus.index)
               CSR_FRAME_WIDTH: begin
                  w_eff_ff <= CNT_W'(clamp_size(csr_bus.data, MAX_WIDTH));
               end
               CSR_FRAME_HEIGHT: begin
                  h_eff_ff <= HCNT_W'(clamp_size(csr_bus.data, MAX_HEIGHT));
               end
               default: begin
               end
            endcase
            state_ff <= ST_STREAM;
            col_ff   <= '0;
            row_ff   <= '0;
         end else begin
            unique case (state_ff)
               ST_STREAM: begin
                  if (req_acc) begin
                     if (last_col) begin
                        col_ff <= '0;
                        if (last_row) begin
                           row_ff   <= '0;
                           state_ff <= ST_WAIT;
                        end else begin
                           row_ff <= ROW_W'(row_next);
                        end
                     end else begin
                        col_ff <= COL_W'(col_next);
                     end
                  end
               end
               ST_WAIT: begin
                  if (!rsp_valid_ff) begin
                     state_ff <= ST_SWEEP;
                  end
               end
               ST_SWEEP: begin
                  if (last_col) begin
                     col_ff   <= '0;
                     state_ff <= ST_STREAM;
                  end else begin
                     col_ff <= COL_W'(col_next);
                  end
               end
               default: begin
                  state_ff <= ST_STREAM;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         addr_ff   <= col_ff;
         sample_ff <= req_bus.sample;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.peak_found  = rsp_ff.found;
   assign rsp_bus.peak_row    = rsp_ff.row;
   assign rsp_bus.peak_column = rsp_ff.col;

endmodule
